[sv/calendar_date_adder_top_assert.svh]
// Assertion macros used by the checker of the calendar date adder.
`ifndef CALENDAR_DATE_ADDER_TOP_ASSERT_SVH
`define CALENDAR_DATE_ADDER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define CDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define CDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/cda_pkg.sv]
// ----------------------------------------------------------------------------
// cda_pkg
// Types, constants and month-length helper for the calendar date adder.
// ----------------------------------------------------------------------------
package cda_pkg;

  localparam int FUNC_W   = 2;
  localparam int YEAR_W   = 14;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int COUNT_W  = 16;
  localparam int STATUS_W = 2;
  localparam int NDAY_W   = 19;
  localparam int QUOT_W   = 8;
  localparam int REM_W    = 7;

  localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'd65535;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

  // Division of the year by 100 through a reciprocal multiply.
  localparam logic [12:0]  RECIP_100   = 13'd5243;
  localparam int           RECIP_SHIFT = 19;
  localparam logic [REM_W-1:0] CENT_LAST = 7'd99;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DAYS,
    FUNC_WEEKS,
    FUNC_MONTHS,
    FUNC_YEARS
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK,
    ST_INVALID,
    ST_OVERFLOW
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT_Q,
    S_INIT_R,
    S_CHECK,
    S_DAYS,
    S_MONTHS,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic calc_q;
    logic calc_r;
    logic check;
    logic step_day;
    logic step_month;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic  date_valid;
    func_t func;
    logic  day_last;
    logic  month_last;
    logic  year_ovf;
    logic  out_free;
  } dp_sts_t;

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - 4'd1;
    if (m == MONTH_FEB) begin
      return leap ? 5'd29 : 5'd28;
    end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
      return MONTH_LEN[idx];
    end else begin
      return 5'd31;
    end
  endfunction

endpackage

[sv/cda_ctrl.sv]
// ----------------------------------------------------------------------------
// cda_ctrl
// Sequencer of the calendar date adder: loads an item, primes the leap-year
// counters, validates the date, steps months until the count is used up and emits the result.
// ----------------------------------------------------------------------------
module cda_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cda_pkg::dp_sts_t   sts,
  output cda_pkg::ctrl_cmd_t cmd
);

  cda_pkg::state_t state_r;
  cda_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cda_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        if (in_valid) state_nxt = cda_pkg::S_INIT_Q;
      end
      cda_pkg::S_INIT_Q: state_nxt = cda_pkg::S_INIT_R;
      cda_pkg::S_INIT_R: state_nxt = cda_pkg::S_CHECK;
      cda_pkg::S_CHECK: begin
        if (!sts.date_valid) begin
          state_nxt = cda_pkg::S_DONE;
        end else begin
          unique case (sts.func) inside
            cda_pkg::FUNC_DAYS, cda_pkg::FUNC_WEEKS: state_nxt = cda_pkg::S_DAYS;
            cda_pkg::FUNC_MONTHS:                    state_nxt = cda_pkg::S_MONTHS;
            default:                                 state_nxt = cda_pkg::S_DONE;
          endcase
        end
      end
      cda_pkg::S_DAYS: begin
        if (sts.day_last || sts.year_ovf) state_nxt = cda_pkg::S_DONE;
      end
      cda_pkg::S_MONTHS: begin
        if (sts.month_last || sts.year_ovf) state_nxt = cda_pkg::S_DONE;
      end
      cda_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = cda_pkg::S_IDLE;
      end
      default: state_nxt = cda_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      cda_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      cda_pkg::S_INIT_Q: cmd.calc_q = 1'b1;
      cda_pkg::S_INIT_R: cmd.calc_r = 1'b1;
      cda_pkg::S_CHECK:  cmd.check  = 1'b1;
      cda_pkg::S_DAYS:   cmd.step_day = 1'b1;
      cda_pkg::S_MONTHS: cmd.step_month = !sts.month_last;
      cda_pkg::S_DONE:   cmd.emit = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

[sv/cda_dp.sv]
// ----------------------------------------------------------------------------
// cda_dp
// Datapath of the calendar date adder: date registers, remaining count,
// leap-year counters and the output register.
// ----------------------------------------------------------------------------
module cda_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [cda_pkg::FUNC_W-1:0]    in_func,
  input  logic [cda_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [cda_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [cda_pkg::DAY_W-1:0]     in_start_day,
  input  logic [cda_pkg::COUNT_W-1:0]   in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cda_pkg::YEAR_W-1:0]    out_result_year,
  output logic [cda_pkg::MONTH_W-1:0]   out_result_month,
  output logic [cda_pkg::DAY_W-1:0]     out_result_day,
  output logic [cda_pkg::STATUS_W-1:0]  out_status,
  input  cda_pkg::ctrl_cmd_t            cmd,
  output cda_pkg::dp_sts_t              sts
);

  cda_pkg::func_t                  func_r,   func_nxt;
  logic [cda_pkg::YEAR_W-1:0]      year_r,   year_nxt;
  logic [cda_pkg::MONTH_W-1:0]     month_r,  month_nxt;
  logic [cda_pkg::DAY_W-1:0]       day_r,    day_nxt;
  logic [cda_pkg::NDAY_W-1:0]      n_r,      n_nxt;
  logic [cda_pkg::QUOT_W-1:0]      q_r,      q_nxt;
  logic [cda_pkg::REM_W-1:0]       r100_r,   r100_nxt;
  logic [1:0]                      cent4_r,  cent4_nxt;
  cda_pkg::status_t                status_r, status_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [cda_pkg::YEAR_W-1:0]      out_year_r,  out_year_nxt;
  logic [cda_pkg::MONTH_W-1:0]     out_month_r, out_month_nxt;
  logic [cda_pkg::DAY_W-1:0]       out_day_r,   out_day_nxt;
  logic [cda_pkg::STATUS_W-1:0]    out_status_r, out_status_nxt;

  logic                            leap;
  logic [cda_pkg::DAY_W-1:0]       dim_cur;
  logic [cda_pkg::DAY_W-1:0]       dim_next;
  logic [cda_pkg::DAY_W-1:0]       left;
  logic [cda_pkg::MONTH_W-1:0]     mon_next;
  logic                            year_wrap;
  logic                            year_ovf;
  logic                            day_last;
  logic                            date_valid;
  logic [cda_pkg::COUNT_W-1:0]     count_sat;
  logic [26:0]                     recip_prod;
  logic [14:0]                     cent_base;
  logic [cda_pkg::YEAR_W+2:0]      year_sum;
  logic                            out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r       <= func_nxt;
    year_r       <= year_nxt;
    month_r      <= month_nxt;
    day_r        <= day_nxt;
    n_r          <= n_nxt;
    q_r          <= q_nxt;
    r100_r       <= r100_nxt;
    cent4_r      <= cent4_nxt;
    status_r     <= status_nxt;
    out_year_r   <= out_year_nxt;
    out_month_r  <= out_month_nxt;
    out_day_r    <= out_day_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    leap       = ((year_r[1:0] == 2'd0) && (r100_r != '0)) ||
                 ((r100_r == '0) && (cent4_r == 2'd0));
    dim_cur    = cda_pkg::month_days(month_r, leap);
    year_wrap  = (month_r == cda_pkg::MONTH_DEC);
    mon_next   = year_wrap ? cda_pkg::MONTH_JAN : month_r + 4'd1;
    dim_next   = cda_pkg::month_days(mon_next, leap);
    year_ovf   = year_wrap && (year_r >= cda_pkg::MAX_YEAR);
    left       = dim_cur - day_r;
    day_last   = (n_r <= cda_pkg::NDAY_W'(left));
    date_valid = (year_r <= cda_pkg::MAX_YEAR) && (month_r >= cda_pkg::MONTH_JAN) &&
                 (month_r <= cda_pkg::MONTH_DEC) && (day_r != '0) && (day_r <= dim_cur);
    count_sat  = (in_count > cda_pkg::COUNT_MAX) ? cda_pkg::COUNT_MAX : in_count;
    recip_prod = 27'(year_r) * 27'(cda_pkg::RECIP_100);
    cent_base  = 15'(q_r) * 15'd100;
    year_sum   = (cda_pkg::YEAR_W+3)'(year_r) +
                 (cda_pkg::YEAR_W+3)'(n_r[cda_pkg::COUNT_W-1:0]);
    out_free   = !out_valid_r || out_ready;
  end

  always_comb begin
    func_nxt       = func_r;
    year_nxt       = year_r;
    month_nxt      = month_r;
    day_nxt        = day_r;
    n_nxt          = n_r;
    q_nxt          = q_r;
    r100_nxt       = r100_r;
    cent4_nxt      = cent4_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_year_nxt   = out_year_r;
    out_month_nxt  = out_month_r;
    out_day_nxt    = out_day_r;
    out_status_nxt = out_status_r;

    if (cmd.load) begin
      func_nxt  = cda_pkg::func_t'(in_func);
      year_nxt  = in_start_year;
      month_nxt = in_start_month;
      day_nxt   = in_start_day;
      n_nxt     = cda_pkg::NDAY_W'(count_sat);
    end

    if (cmd.calc_q) begin
      q_nxt = recip_prod[cda_pkg::RECIP_SHIFT +: cda_pkg::QUOT_W];
    end

    if (cmd.calc_r) begin
      r100_nxt  = cda_pkg::REM_W'(15'(year_r) - cent_base);
      cent4_nxt = q_r[1:0];
    end

    if (cmd.check) begin
      status_nxt = date_valid ? cda_pkg::ST_OK : cda_pkg::ST_INVALID;
      if (func_r == cda_pkg::FUNC_WEEKS) begin
        n_nxt = (n_r << 3) - n_r;
      end
      if (date_valid && (func_r == cda_pkg::FUNC_YEARS)) begin
        if (year_sum > (cda_pkg::YEAR_W+3)'(cda_pkg::MAX_YEAR)) begin
          year_nxt   = cda_pkg::MAX_YEAR;
          month_nxt  = cda_pkg::MONTH_DEC;
          day_nxt    = cda_pkg::DAY_LAST_DEC;
          status_nxt = cda_pkg::ST_OVERFLOW;
        end else begin
          year_nxt = year_sum[cda_pkg::YEAR_W-1:0];
        end
      end
    end

    if (cmd.step_day || cmd.step_month) begin
      if (cmd.step_day && day_last) begin
        day_nxt = day_r + n_r[cda_pkg::DAY_W-1:0];
      end else if (year_ovf) begin
        year_nxt   = cda_pkg::MAX_YEAR;
        month_nxt  = cda_pkg::MONTH_DEC;
        day_nxt    = cda_pkg::DAY_LAST_DEC;
        status_nxt = cda_pkg::ST_OVERFLOW;
      end else begin
        month_nxt = mon_next;
        if (year_wrap) begin
          year_nxt = year_r + 14'd1;
          if (r100_r == cda_pkg::CENT_LAST) begin
            r100_nxt  = '0;
            cent4_nxt = cent4_r + 2'd1;
          end else begin
            r100_nxt = r100_r + 7'd1;
          end
        end
        if (cmd.step_day) begin
          n_nxt   = n_r - cda_pkg::NDAY_W'(left) - 19'd1;
          day_nxt = 5'd1;
        end else begin
          n_nxt   = n_r - 19'd1;
          day_nxt = (day_r > dim_next) ? dim_next : day_r;
        end
      end
    end

    if (cmd.emit) begin
      out_valid_nxt  = 1'b1;
      out_year_nxt   = year_r;
      out_month_nxt  = month_r;
      out_day_nxt    = day_r;
      out_status_nxt = status_r;
    end
  end

  assign sts.date_valid = date_valid;
  assign sts.func       = func_r;
  assign sts.day_last   = day_last;
  assign sts.month_last = (n_r == '0);
  assign sts.year_ovf   = year_ovf;
  assign sts.out_free   = out_free;

  assign out_valid        = out_valid_r;
  assign out_result_year  = out_year_r;
  assign out_result_month = out_month_r;
  assign out_result_day   = out_day_r;
  assign out_status       = out_status_r;

endmodule

[sv/calendar_date_adder_top.sv]
// ----------------------------------------------------------------------------
// calendar_date_adder_top
// Adds days, weeks, months or years to a Gregorian date.
// ----------------------------------------------------------------------------
// One transaction at a time: the date is loaded at acceptance, and the block
// then primes its leap-year counters (quotient, then remainder by 100) and
// validates the date. Year additions and invalid dates then finish at once. Day
// and week additions step across month boundaries, and month additions step
// month by month, until the count is used up or the year overflows; both share
// the single month-step unit in the datapath. A last state hands the result to an
// output register, so the next transaction is accepted while a finished
// result waits.
module calendar_date_adder_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cda_pkg::FUNC_W-1:0]    in_func,
  input  logic [cda_pkg::YEAR_W-1:0]    in_start_year,
  input  logic [cda_pkg::MONTH_W-1:0]   in_start_month,
  input  logic [cda_pkg::DAY_W-1:0]     in_start_day,
  input  logic [cda_pkg::COUNT_W-1:0]   in_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cda_pkg::YEAR_W-1:0]    out_result_year,
  output logic [cda_pkg::MONTH_W-1:0]   out_result_month,
  output logic [cda_pkg::DAY_W-1:0]     out_result_day,
  output logic [cda_pkg::STATUS_W-1:0]  out_status
);

  cda_pkg::ctrl_cmd_t cmd;
  cda_pkg::dp_sts_t   sts;

  cda_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cda_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_func          (in_func),
    .in_start_year    (in_start_year),
    .in_start_month   (in_start_month),
    .in_start_day     (in_start_day),
    .in_count         (in_count),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_year  (out_result_year),
    .out_result_month (out_result_month),
    .out_result_day   (out_result_day),
    .out_status       (out_status),
    .cmd              (cmd),
    .sts              (sts)
  );

endmodule

[sv/cda_checker.sv]
// ----------------------------------------------------------------------------
// cda_checker
// Port-level checks of the calendar date adder, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_date_adder_top_assert.svh"

module cda_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cda_pkg::YEAR_W-1:0]    out_result_year,
  input logic [cda_pkg::MONTH_W-1:0]   out_result_month,
  input logic [cda_pkg::DAY_W-1:0]     out_result_day,
  input logic [cda_pkg::STATUS_W-1:0]  out_status
);

  `CDA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                  out_valid && $stable(out_result_year) && $stable(out_result_month) &&
                  $stable(out_result_day) && $stable(out_status),
                  "Stalled result changed.")

  `CDA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
                  "Block ready again right after accepting a transaction.")

  `CDA_ASSERT_IMP(a_status_code, out_valid,
                  out_status == cda_pkg::ST_OK || out_status == cda_pkg::ST_INVALID ||
                  out_status == cda_pkg::ST_OVERFLOW,
                  "Unknown status code.")

  `CDA_ASSERT_IMP(a_overflow_date, out_valid && out_status == cda_pkg::ST_OVERFLOW,
                  out_result_year == cda_pkg::MAX_YEAR &&
                  out_result_month == cda_pkg::MONTH_DEC &&
                  out_result_day == cda_pkg::DAY_LAST_DEC,
                  "Overflow result is not the last day.")

  `CDA_ASSERT_IMP(a_ok_range, out_valid && out_status == cda_pkg::ST_OK,
                  out_result_year <= cda_pkg::MAX_YEAR &&
                  out_result_month >= cda_pkg::MONTH_JAN &&
                  out_result_month <= cda_pkg::MONTH_DEC && out_result_day != 5'd0,
                  "Successful result out of range.")

endmodule

bind calendar_date_adder_top cda_checker u_cda_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_year  (out_result_year),
  .out_result_month (out_result_month),
  .out_result_day   (out_result_day),
  .out_status       (out_status)
);
